/* rtl/core/fil_pkg.sv */
// fil_pkg: shared types and constants of the frequent item line filter
// used by the top level, its port checker and the bench, depends on nothing

package fil_pkg;

    localparam int ITEM_SLOTS_DEF = 65536;
    localparam int LINE_BITS_DEF  = 24;

    // field widths fixed by the stream format
    localparam int BYTE_W   = 8;
    localparam int FIDX_W   = 16;
    localparam int OUT_W    = 24;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;

    // kinds of input word, carried on s_tuser
    localparam logic ACT_TABLE_WRITE = 1'b0;
    localparam logic ACT_TEXT        = 1'b1;

    // character codes
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam int                RADIX        = 10;

    typedef struct packed {
        logic valid;
        logic newline;
        logic lookup;
    } fil_s1_t;

endpackage

/* rtl/core/frequent_item_line_filter.sv */
// frequent_item_line_filter: scans transaction text and emits kept lines
// holds the frequent flag table ram and the scan pipeline, depends on fil_pkg
//
// usage
//   s_ channel: one word per cycle. s_tuser = 1 carries a text byte in
//   s_tdata[7:0]; s_tuser = 0 writes the frequent flag s_tdata[24] into the
//   table at index s_tdata[23:8] (indexes of ITEM_SLOTS or more are dropped)
//   m_ channel: one word per kept line, {kept_ordinal, line_number}
//   throughput: one word per cycle in either kind, sustained, as long as the
//   receiver takes results; the only pause is a newline whose result meets
//   a full, stalled output register
//   result path: a newline passes the stage 1 register, then the output
//   register; the flag table ram is looked up when an item ends and
//   answers in the next stage
//   reset: aresetn low clears the scan state, counters and valid flags;
//   the flag table is not cleared and must be loaded before use
//   stall: a result waits in the output register; bytes keep flowing until
//   a second result would need that register, then s_tready drops
//   a line without a final newline never produces a result

module frequent_item_line_filter
    import fil_pkg::*;
#(
    parameter int ITEM_SLOTS = ITEM_SLOTS_DEF,
    parameter int LINE_BITS  = LINE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // s_tdata: text_byte[7:0], flag_index[23:8], flag_value[24], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: action (0 table write, 1 text byte)
    input  logic                s_tuser,
    input  logic                s_tvalid,
    output logic                s_tready,
    // m_tdata: line_number[23:0], kept_ordinal[47:24]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready
);

    localparam int IDX_W = (ITEM_SLOTS > 1) ? $clog2(ITEM_SLOTS) : 1;
    localparam int NXT_W = IDX_W + 4;
    localparam logic [NXT_W-1:0] SLOTS_V = NXT_W'(ITEM_SLOTS);

    // input word fields
    logic [BYTE_W-1:0] text_byte;
    logic [FIDX_W-1:0] flag_index;
    logic              flag_value;
    logic              s_accept;

    assign text_byte  = s_tdata[BYTE_W-1:0];
    assign flag_index = s_tdata[BYTE_W+FIDX_W-1:BYTE_W];
    assign flag_value = s_tdata[BYTE_W+FIDX_W];
    assign s_accept   = s_tvalid & s_tready;

    // flag table ram, one port, registered read
    logic              flag_mem [ITEM_SLOTS];
    logic              rd_data_reg;

    // item scan state
    logic [IDX_W-1:0]  acc_reg,   acc_next;
    logic              ovf_reg,   ovf_next;
    logic              digit_reg, digit_next;

    // second stage, waiting on the ram answer
    fil_s1_t           s1_reg, s1_next;
    logic              line_freq_reg, line_freq_next;
    logic [LINE_BITS-1:0] line_cnt_reg, line_cnt_next;
    logic [LINE_BITS-1:0] kept_cnt_reg, kept_cnt_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    // decode of the accepted word
    logic              is_text, is_digit, is_newline;
    logic [3:0]        digit_val;
    logic [NXT_W-1:0]  acc_mul;
    logic              tbl_wr, tbl_rd;
    logic [IDX_W-1:0]  wr_addr;
    logic [31:0]       fidx_ext;

    // stage 1 decisions
    logic              item_freq, emit, stall1;
    logic [31:0]       line_ext, kept_ext;

    assign is_text    = (s_tuser == ACT_TEXT);
    assign is_digit   = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    assign is_newline = (text_byte == CHAR_NEWLINE);
    assign digit_val  = 4'(text_byte - CHAR_ZERO);
    assign acc_mul    = NXT_W'(acc_reg) * NXT_W'(RADIX) + NXT_W'(digit_val);

    assign fidx_ext   = 32'(flag_index);
    assign wr_addr    = fidx_ext[IDX_W-1:0];
    assign tbl_wr     = s_accept && !is_text && (fidx_ext < 32'(ITEM_SLOTS));
    // only items with a digit and no saturation are checked
    assign tbl_rd     = s_accept && is_text && !is_digit && digit_reg && !ovf_reg;

    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            flag_mem[wr_addr] <= flag_value;
        end
        if (tbl_rd) begin
            rd_data_reg <= flag_mem[acc_reg];
        end
    end

    // stage 1: ram answer meets the line state
    assign item_freq = s1_reg.lookup & rd_data_reg;
    assign emit      = s1_reg.valid & s1_reg.newline & (line_freq_reg | item_freq);
    assign stall1    = emit & m_valid_reg & ~m_tready;
    assign s_tready  = ~stall1;

    assign line_ext  = 32'(line_cnt_reg);
    assign kept_ext  = 32'(kept_cnt_reg);

    always_comb begin
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        digit_next = digit_reg;
        s1_next    = s1_reg;

        if (!stall1) begin
            s1_next = '0;
        end
        if (s_accept && is_text) begin
            if (is_digit) begin
                digit_next = 1'b1;
                if (!ovf_reg) begin
                    if (acc_mul >= SLOTS_V) begin
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = acc_mul[IDX_W-1:0];
                    end
                end
            end else begin
                // separator or newline ends the item
                acc_next       = '0;
                ovf_next       = 1'b0;
                digit_next     = 1'b0;
                s1_next.valid   = is_newline | tbl_rd;
                s1_next.newline = is_newline;
                s1_next.lookup  = tbl_rd;
            end
        end
    end

    always_comb begin
        line_freq_next = line_freq_reg;
        line_cnt_next  = line_cnt_reg;
        kept_cnt_next  = kept_cnt_reg;
        m_valid_next   = m_valid_reg & ~m_tready;
        m_data_next    = m_data_reg;

        if (s1_reg.valid && !stall1) begin
            if (s1_reg.newline) begin
                if (emit) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = {kept_ext[OUT_W-1:0], line_ext[OUT_W-1:0]};
                    kept_cnt_next = kept_cnt_reg + 1'b1;
                end
                line_cnt_next  = line_cnt_reg + 1'b1;
                line_freq_next = 1'b0;
            end else begin
                line_freq_next = line_freq_reg | item_freq;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            digit_reg     <= 1'b0;
            s1_reg        <= '0;
            line_freq_reg <= 1'b0;
            line_cnt_reg  <= '0;
            kept_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            digit_reg     <= digit_next;
            s1_reg        <= s1_next;
            line_freq_reg <= line_freq_next;
            line_cnt_reg  <= line_cnt_next;
            kept_cnt_reg  <= kept_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* rtl/core/fil_checker.sv */
// fil_checker: port level assertions for the frequent item line filter
// bound to the top level below, depends on fil_pkg

module fil_checker
    import fil_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                s_tuser,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tvalid,
    input logic                m_tready
);

    // a result is held until taken
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a fresh result follows a newline word, through stage 1 and the output register
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == ACT_TEXT)
            && (s_tdata[BYTE_W-1:0] == CHAR_NEWLINE), 2))
        else $error("result without a newline word");

endmodule

bind frequent_item_line_filter fil_checker u_fil_checker (.*);

/* tb/sv/tb_top.sv */
// tb_top: self-checking bench for frequent_item_line_filter
// streams flag table loads and transaction text, predicts kept lines in step
// depends on fil_pkg and the frequent_item_line_filter rtl

module tb_top;
    import fil_pkg::*;

    localparam int DIR_ROWS     = 24;
    localparam int RANDOM_WORDS = 1700;
    localparam int IDLE_LIMIT   = 5000;   // cycles with no word moving on either side
    localparam int LONG_HOLD    = 600;    // receiver hold-off that backs up the input
    localparam int DRAIN_CYCLES = 8;

    // one kept line as the block reports it
    typedef struct packed {
        logic [OUT_W-1:0] line_number;
        logic [OUT_W-1:0] kept_ordinal;
    } kept_line_t;

    // one row of the directed stimulus; typed rows carry their result by hand
    typedef struct packed {
        logic             act;
        logic [BYTE_W-1:0] chr;
        logic [FIDX_W-1:0] idx;
        logic             val;
        logic             typed;
        logic [OUT_W-1:0] t_line;
        logic [OUT_W-1:0] t_kept;
    } dir_row_t;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_STARVE,
        RX_EVERY3
    } rx_mode_t;

    logic                aclk;
    logic                aresetn;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                s_tvalid;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready;

    frequent_item_line_filter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // shadow copy of the scan state and the flag table
    bit               flag_bits [0:ITEM_SLOTS_DEF-1];
    logic [FIDX_W-1:0] item_acc;
    bit               item_ovf;
    bit               item_dig;
    bit               line_hit;
    logic [OUT_W-1:0] line_cnt;
    logic [OUT_W-1:0] kept_cnt;

    kept_line_t       kept_line_q [$];    // kept lines still owed by the block
    logic [FIDX_W-1:0] flag_pool [$];     // indexes loaded so far, safe to look up
    dir_row_t         dir_rows [DIR_ROWS];
    kept_line_t       exp_line;

    int words_sent;
    int flag_writes;
    int results_seen;
    int mismatch_count;
    int idle_cycles;
    int burst_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // advance the shadow scan by one accepted word, report a kept line if one ends
    function automatic void scan_text_word(input logic act, input logic [BYTE_W-1:0] chr,
                                           input logic [FIDX_W-1:0] idx, input logic val,
                                           output bit hit, output kept_line_t res);
        int acc_next;
        hit = 1'b0;
        res = '0;
        if (act == ACT_TABLE_WRITE) begin
            // the whole 16-bit index range fits the table, so every write lands
            flag_bits[idx] = val;
            return;
        end
        if (chr >= CHAR_ZERO && chr <= CHAR_NINE) begin
            item_dig = 1'b1;
            if (!item_ovf) begin
                acc_next = int'(item_acc) * RADIX + int'(chr - CHAR_ZERO);
                if (acc_next >= ITEM_SLOTS_DEF)
                    item_ovf = 1'b1;    // saturate, the item counts as infrequent
                else
                    item_acc = acc_next[FIDX_W-1:0];
            end
        end else begin
            // any non-digit ends the item; only items with a digit are looked up
            if (item_dig && !item_ovf && flag_bits[item_acc])
                line_hit = 1'b1;
            item_acc = '0;
            item_ovf = 1'b0;
            item_dig = 1'b0;
            if (chr == CHAR_NEWLINE) begin
                if (line_hit) begin
                    hit              = 1'b1;
                    res.line_number  = line_cnt;
                    res.kept_ordinal = kept_cnt;
                    kept_cnt         = kept_cnt + 1'b1;
                end
                line_cnt = line_cnt + 1'b1;
                line_hit = 1'b0;
            end
        end
    endfunction

    // offer one word, hold it until taken, then predict and maybe pause
    task automatic send_word(input logic act, input logic [BYTE_W-1:0] chr,
                             input logic [FIDX_W-1:0] idx, input logic val,
                             input logic typed, input logic [OUT_W-1:0] t_line,
                             input logic [OUT_W-1:0] t_kept);
        bit         hit;
        kept_line_t res;
        int         gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, val, idx, chr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        if (act == ACT_TABLE_WRITE)
            flag_writes++;
        scan_text_word(act, chr, idx, val, hit, res);
        if (typed) begin
            res.line_number  = t_line;
            res.kept_ordinal = t_kept;
            hit              = 1'b1;
        end
        if (hit)
            kept_line_q.push_back(res);
        // burst accounting: a gap only after a burst runs out
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // load one flag, either a fresh random index or a reload of a known one
    task automatic random_flag_write(input bit fresh);
        logic [FIDX_W-1:0] idx;
        if (!fresh && flag_pool.size() > 0 && $urandom_range(0, 9) < 7) begin
            idx = flag_pool[$urandom_range(0, flag_pool.size() - 1)];
        end else begin
            idx = FIDX_W'($urandom);
            flag_pool.push_back(idx);
        end
        send_word(ACT_TABLE_WRITE, BYTE_W'($urandom), idx, 1'($urandom), 1'b0, '0, '0);
    endtask

    // one text byte with junk in the unused fields, sometimes after a table load
    task automatic send_text(input logic [BYTE_W-1:0] chr);
        if ($urandom_range(0, 99) < 6)
            random_flag_write(1'b0);
        send_word(ACT_TEXT, chr, FIDX_W'($urandom), 1'($urandom), 1'b0, '0, '0);
    endtask

    // decimal text of an item number, with optional leading zeros
    task automatic send_number(input int unsigned num, input int zeros);
        string s;
        s = $sformatf("%0d", num);
        repeat (zeros) send_text(CHAR_ZERO);
        for (int i = 0; i < s.len(); i++)
            send_text(s[i]);
    endtask

    // random non-digit byte, newline only when asked for
    function automatic logic [BYTE_W-1:0] pick_separator(input bit allow_nl);
        logic [BYTE_W-1:0] b;
        do begin
            b = BYTE_W'($urandom_range(0, 255));
        end while ((b >= CHAR_ZERO && b <= CHAR_NINE) || (!allow_nl && b == CHAR_NEWLINE));
        return b;
    endfunction

    // receiver: segments of different stall patterns, one long hold-off
    initial begin
        int       seg_no;
        int       seg_len;
        rx_mode_t mode;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        seg_no = 0;
        forever begin
            if (seg_no == 4) begin
                // long hold-off: results pile up and the input has to stall
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                seg_len = $urandom_range(20, 200);
                mode    = rx_mode_t'($urandom_range(0, 3));
                for (int k = 0; k < seg_len; k++) begin
                    case (mode)
                        RX_OPEN: begin
                            m_tready <= 1'b1;
                        end
                        RX_COIN: begin
                            m_tready <= 1'($urandom_range(0, 1));
                        end
                        RX_STARVE: begin
                            m_tready <= ($urandom_range(0, 3) == 0);
                        end
                        default: begin
                            m_tready <= (k % 3 == 0);
                        end
                    endcase
                    @(posedge aclk);
                end
            end
            seg_no++;
        end
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog, no word moved for %0d cycles, %0d kept lines owed",
                         $time, IDLE_LIMIT, kept_line_q.size());
                $display("tb_top: done, errors");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (kept_line_q.size() == 0) begin
                    $display("%0t: unexpected kept line, line_number %0d kept_ordinal %0d",
                             $time, m_tdata[OUT_W-1:0], m_tdata[M_DATA_W-1:OUT_W]);
                    mismatch_count++;
                end else begin
                    exp_line = kept_line_q.pop_front();
                    if (m_tdata[OUT_W-1:0] !== exp_line.line_number) begin
                        $display("%0t: line_number expected %0d got %0d",
                                 $time, exp_line.line_number, m_tdata[OUT_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[M_DATA_W-1:OUT_W] !== exp_line.kept_ordinal) begin
                        $display("%0t: kept_ordinal expected %0d got %0d",
                                 $time, exp_line.kept_ordinal, m_tdata[M_DATA_W-1:OUT_W]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        int r;
        int ntok;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= 1'b0;
        s_tdata  <= '0;

        item_acc       = '0;
        item_ovf       = 1'b0;
        item_dig       = 1'b0;
        line_hit       = 1'b0;
        line_cnt       = '0;
        kept_cnt       = '0;
        words_sent     = 0;
        flag_writes    = 0;
        results_seen   = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        burst_left     = 1;

        // directed rows: loads at both index extremes, first and last digit,
        // an item with no digit, a load in the middle of an item, a number
        // that saturates, a non-ascii separator
        dir_rows = '{
            '{ACT_TABLE_WRITE, 8'h00,             16'd0,     1'b1, 1'b0, 24'd0, 24'd0},
            '{ACT_TABLE_WRITE, 8'h00,             16'd65535, 1'b1, 1'b0, 24'd0, 24'd0},
            '{ACT_TABLE_WRITE, 8'h00,             16'd7,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TABLE_WRITE, 8'h00,             16'd12345, 1'b1, 1'b0, 24'd0, 24'd0},
            // "0\n": frequent item, first kept line
            '{ACT_TEXT,        CHAR_ZERO,         16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_NEWLINE,      16'd0,     1'b0, 1'b1, 24'd0, 24'd0},
            // "7\n": infrequent, dropped
            '{ACT_TEXT,        CHAR_ZERO + 8'd7,  16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_NEWLINE,      16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            // empty line, nothing looked up
            '{ACT_TEXT,        CHAR_NEWLINE,      16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            // "655" load "35\n": largest index, load does not disturb the scan
            '{ACT_TEXT,        CHAR_ZERO + 8'd6,  16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_ZERO + 8'd5,  16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_ZERO + 8'd5,  16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TABLE_WRITE, 8'h00,             16'd12345, 1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_ZERO + 8'd3,  16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_ZERO + 8'd5,  16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_NEWLINE,      16'd0,     1'b0, 1'b1, 24'd3, 24'd1},
            // "99999" saturates, 0xff separates, then "0\n" keeps the line
            '{ACT_TEXT,        CHAR_NINE,         16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_NINE,         16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_NINE,         16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_NINE,         16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_NINE,         16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        8'hFF,             16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_ZERO,         16'd0,     1'b0, 1'b0, 24'd0, 24'd0},
            '{ACT_TEXT,        CHAR_NEWLINE,      16'd0,     1'b0, 1'b1, 24'd4, 24'd2}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].act == ACT_TABLE_WRITE)
                flag_pool.push_back(dir_rows[i].idx);
            send_word(dir_rows[i].act, dir_rows[i].chr, dir_rows[i].idx, dir_rows[i].val,
                      dir_rows[i].typed, dir_rows[i].t_line, dir_rows[i].t_kept);
        end

        // load a spread of random indexes before random text uses them
        repeat (48) random_flag_write(1'b1);

        // random lines: mostly well-formed item lists, some noise lines
        while (words_sent < DIR_ROWS + RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // noise: any non-digit bytes, newlines among them
                repeat ($urandom_range(1, 8)) send_text(pick_separator(1'b1));
                send_text(CHAR_NEWLINE);
            end else begin
                ntok = $urandom_range(1, 4);
                for (int t = 0; t < ntok; t++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_text(pick_separator(1'b0));    // item with no digit
                    if ($urandom_range(0, 99) < 85) begin
                        send_number(32'(flag_pool[$urandom_range(0, flag_pool.size() - 1)]),
                                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
                    end else if ($urandom_range(0, 1) == 0) begin
                        send_number($urandom_range(ITEM_SLOTS_DEF, 99999999), 0);
                    end else begin
                        // long digit run, well past saturation
                        send_text(CHAR_ZERO + BYTE_W'($urandom_range(1, 9)));
                        repeat ($urandom_range(5, 20))
                            send_text(CHAR_ZERO + BYTE_W'($urandom_range(0, 9)));
                    end
                    if (t < ntok - 1 || $urandom_range(0, 1) == 0)
                        send_text(($urandom_range(0, 9) < 7) ? 8'h20 : pick_separator(1'b0));
                end
                send_text(CHAR_NEWLINE);
            end
        end

        // a last line with no newline must never show up
        send_number(32'(flag_pool[0]), 0);
        s_tvalid <= 1'b0;

        while (kept_line_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb_top: %0d words sent, %0d of them flag loads, %0d lines scanned",
                 words_sent, flag_writes, line_cnt);
        $display("tb_top: %0d kept lines compared, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* frequent_item_line_filter.f */
rtl/core/fil_pkg.sv
rtl/core/frequent_item_line_filter.sv
rtl/core/fil_checker.sv
tb/sv/tb_top.sv
